// ----- sv/qmpg_pkg.sv -----
// Shared types and constants for the quadrature mouse pulse generator.
// Used by the controller, the datapath, the divider and the top level.
package qmpg_pkg;

    localparam int unsigned QUO_W   = 14;
    localparam int unsigned DIVS_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned DUE_W   = 18;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned IDX_W   = 2;

    localparam logic [LEN_W-1:0]  LEN_RESET = 16'd4000;
    localparam logic [DIVS_W-1:0] CAP_RESET = 8'd100;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_MOVE    = 2'd1,
        ACT_BUTTONS = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_SPEED_CAP     = 2'd1
    } t_reg_index;

    typedef struct packed {
        logic exec;
        logic capture;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic open;
        logic div_done;
    } t_status;

endpackage

// ----- sv/quadrature_mouse_pulse_generator.sv -----
// Quadrature mouse pulse generator top level: controller plus datapath.
// Each accepted item's result is registered in S_OUT; a tick that opens a window
// first waits in S_DIV on two parallel 14-step serial dividers and captures the
// quotients in S_FIN. No new item is accepted until the last result is taken.
// Reset (i_rst_n low, synchronous): accumulators, window and phases clear,
// button lines low, window_length 4000, speed_cap 100.
module quadrature_mouse_pulse_generator
    import qmpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // delta_x[15:0], delta_y[31:16], left_pressed[32],
                                           // right_pressed[33], middle_pressed[34], zero pad
    input  logic [1:0]        i_s_tuser,   // action[1:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // horiz_lines[1:0], vert_lines[3:2],
                                           // button_lines[6:4], window_busy[7]
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    qmpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    qmpg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_action    (i_s_tuser),
        .i_delta_x   (i_s_tdata[15:0]),
        .i_delta_y   (i_s_tdata[31:16]),
        .i_left      (i_s_tdata[32]),
        .i_right     (i_s_tdata[33]),
        .i_middle    (i_s_tdata[34]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tdata     (o_m_tdata)
    );

endmodule

// ----- sv/qmpg_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on qmpg_pkg for the operand widths.
module qmpg_div
    import qmpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QUO_W-1:0]  i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    localparam int unsigned CNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_divisor;
    logic [QUO_W-1:0]  r_quo;
    logic [DIVS_W:0]   w_trial;
    logic [DIVS_W:0]   w_diff;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_fit   = w_trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sv/qmpg_ctrl.sv -----
// Sequencer for item execution, window capture and result hand-off.
// Depends on qmpg_pkg for the command and status structs.
module qmpg_ctrl
    import qmpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_m_valid;
    logic   w_ready;
    logic   w_exec;

    assign w_ready = (r_state == S_IDLE) && !r_m_valid;
    assign w_exec  = w_ready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready) r_m_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_exec) r_state <= i_status.open ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (i_status.div_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_m_valid <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready     = w_ready;
    assign o_m_tvalid     = r_m_valid;
    assign o_cmd.exec     = w_exec;
    assign o_cmd.capture  = (r_state == S_FIN);
    assign o_cmd.out_load = (r_state == S_OUT);

endmodule

// ----- sv/qmpg_dp.sv -----
// Accumulators, window timing, phase stepping, buttons and config registers.
// Depends on qmpg_pkg and instantiates two qmpg_div interval dividers.
module qmpg_dp
    import qmpg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [1:0]              i_action,
    input  logic signed [ACC_W-1:0] i_delta_x,
    input  logic signed [ACC_W-1:0] i_delta_y,
    input  logic                    i_left,
    input  logic                    i_right,
    input  logic                    i_middle,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [LEN_W-1:0]        i_cfg_data,
    output logic [7:0]              o_tdata
);

    localparam logic signed [ACC_W:0] ACC_MAX = 17'sd32767;
    localparam logic signed [ACC_W:0] ACC_MIN = -17'sd32767;

    logic [LEN_W-1:0]        r_len;
    logic [DIVS_W-1:0]       r_cap;
    logic signed [ACC_W-1:0] r_pend_x, r_pend_y;
    logic                    r_busy;
    logic [LEN_W-1:0]        r_elapsed;
    logic [QUO_W-1:0]        r_x_int, r_y_int;
    logic [DUE_W-1:0]        r_x_due, r_y_due;
    logic                    r_x_fwd, r_y_fwd;
    logic                    r_x_zero, r_y_zero;
    logic [1:0]              r_x_ph, r_y_ph;
    logic [2:0]              r_buttons;
    logic [7:0]              r_tdata;

    logic [LEN_W-1:0]  w_elapsed;
    logic [DIVS_W-1:0] w_x_mag, w_y_mag;
    logic              w_open;
    logic              w_start;
    logic              w_x_done, w_y_done;
    logic [QUO_W-1:0]  w_x_quo, w_y_quo;
    logic [QUO_W-1:0]  w_x_int, w_y_int;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [ACC_W-1:0] d
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + {d[ACC_W-1], d};
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [DIVS_W-1:0] capped_mag(
        input logic signed [ACC_W-1:0] p,
        input logic [DIVS_W-1:0]       cap
    );
        logic [ACC_W-1:0] m;
        m = p[ACC_W-1] ? ACC_W'(-p) : ACC_W'(p);
        return (m > {{(ACC_W-DIVS_W){1'b0}}, cap}) ? cap : m[DIVS_W-1:0];
    endfunction

    function automatic logic [1:0] advance(input logic [1:0] ph, input logic fwd);
        logic [1:0] n;
        unique case (ph)
            2'd0:    n = fwd ? 2'd1 : 2'd2;
            2'd1:    n = fwd ? 2'd3 : 2'd0;
            2'd3:    n = fwd ? 2'd2 : 2'd1;
            default: n = fwd ? 2'd0 : 2'd3;
        endcase
        return n;
    endfunction

    assign w_elapsed = r_elapsed + 1'b1;
    assign w_x_mag   = capped_mag(r_pend_x, r_cap);
    assign w_y_mag   = capped_mag(r_pend_y, r_cap);
    assign w_open    = (t_action'(i_action) == ACT_TICK) && !r_busy
                       && ((r_pend_x != '0) || (r_pend_y != '0));
    assign w_start   = i_cmd.exec && w_open;
    assign w_x_int   = r_x_zero ? '0 : w_x_quo;
    assign w_y_int   = r_y_zero ? '0 : w_y_quo;

    qmpg_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_len[LEN_W-1:2]),
        .i_divisor  (w_x_mag),
        .o_done     (w_x_done),
        .o_quotient (w_x_quo)
    );

    qmpg_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_len[LEN_W-1:2]),
        .i_divisor  (w_y_mag),
        .o_done     (w_y_done),
        .o_quotient (w_y_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_RESET;
            r_cap     <= CAP_RESET;
            r_pend_x  <= '0;
            r_pend_y  <= '0;
            r_busy    <= 1'b0;
            r_elapsed <= '0;
            r_x_int   <= '0;
            r_y_int   <= '0;
            r_x_due   <= '0;
            r_y_due   <= '0;
            r_x_fwd   <= 1'b0;
            r_y_fwd   <= 1'b0;
            r_x_zero  <= 1'b1;
            r_y_zero  <= 1'b1;
            r_x_ph    <= '0;
            r_y_ph    <= '0;
            r_buttons <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WINDOW_LENGTH: r_len <= i_cfg_data;
                    REG_SPEED_CAP:     r_cap <= i_cfg_data[DIVS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                unique case (t_action'(i_action))
                    ACT_TICK: begin
                        if (w_open) begin
                            r_x_fwd  <= !r_pend_x[ACC_W-1] && (r_pend_x != '0);
                            r_y_fwd  <= !r_pend_y[ACC_W-1] && (r_pend_y != '0);
                            r_x_zero <= (w_x_mag == '0);
                            r_y_zero <= (w_y_mag == '0);
                            r_pend_x <= '0;
                            r_pend_y <= '0;
                        end else if (r_busy) begin
                            r_elapsed <= w_elapsed;
                            if ({2'b00, w_elapsed} > r_x_due) begin
                                r_x_ph  <= advance(r_x_ph, r_x_fwd);
                                r_x_due <= r_x_due + {4'b0, r_x_int};
                            end
                            if ({2'b00, w_elapsed} > r_y_due) begin
                                r_y_ph  <= advance(r_y_ph, r_y_fwd);
                                r_y_due <= r_y_due + {4'b0, r_y_int};
                            end
                            if (w_elapsed >= r_len) r_busy <= 1'b0;
                        end
                    end
                    ACT_MOVE: begin
                        r_pend_x <= sat_add(r_pend_x, i_delta_x);
                        r_pend_y <= sat_add(r_pend_y, i_delta_y);
                    end
                    ACT_BUTTONS: r_buttons <= ~{i_middle, i_right, i_left};
                    ACT_NONE: ;
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_x_int   <= w_x_int;
                r_y_int   <= w_y_int;
                r_x_due   <= (w_x_int != '0) ? {4'b0, w_x_int} : {1'b0, r_len, 1'b0};
                r_y_due   <= (w_y_int != '0) ? {4'b0, w_y_int} : {1'b0, r_len, 1'b0};
                r_elapsed <= '0;
                r_busy    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_tdata <= {r_busy, r_buttons, r_y_ph, r_x_ph};
    end

    assign o_status.open     = w_open;
    assign o_status.div_done = w_x_done && w_y_done;
    assign o_tdata           = r_tdata;

endmodule
